@@ sv/json_string_unescape_assert.svh @@
// Assertion macros used by the string unescaper RTL.
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ sv/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// jsu_pkg
// Result kinds and the job record passed from the front end to the back end.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam logic [2:0] K_BYTE    = 3'd0;
    localparam logic [2:0] K_END     = 3'd1;
    localparam logic [2:0] K_NOQUOTE = 3'd2;
    localparam logic [2:0] K_UNTERM  = 3'd3;
    localparam logic [2:0] K_BADHEX  = 3'd4;
    localparam logic [2:0] K_BADESC  = 3'd5;

    // One input byte's worth of results: 1 to 3 of them.
    typedef struct packed {
        logic [2:0]      kind;
        logic [1:0]      last_idx;   // index of the final result, 0..2
        logic [2:0][7:0] bytes;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ sv/jsu_front.sv @@
// ----------------------------------------------------------------------------
// jsu_front
// Input side: tracks string/escape/hex mode and turns bytes into jobs.
// ----------------------------------------------------------------------------
module jsu_front
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  t_q_stat    i_q_stat,
    output logic       o_ready,
    output logic       o_push,
    output t_job       o_job
);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_STR  = 2'd1;
    localparam logic [1:0] M_ESC  = 2'd2;
    localparam logic [1:0] M_HEX  = 2'd3;

    localparam logic [7:0] C_QUOTE = 8'h22;
    localparam logic [7:0] C_BSL   = 8'h5c;
    localparam logic [7:0] C_SLASH = 8'h2f;
    localparam logic [7:0] C_NUL   = 8'h00;

    logic [1:0]  r_mode, n_mode;
    logic [1:0]  r_hex_cnt, n_hex_cnt;
    logic [11:0] r_acc, n_acc;
    logic        w_take;
    logic        w_has;
    logic [4:0]  w_hex;
    logic [15:0] w_code;

    // {bad, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
        if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
        if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
        return r;
    endfunction

    assign o_ready = !i_q_stat.full;
    assign w_take  = i_valid && o_ready;
    assign w_hex   = hex_decode(i_byte);
    assign w_code  = {r_acc, w_hex[3:0]};
    assign o_push  = w_take && w_has;

    always_comb begin
        n_mode    = r_mode;
        n_hex_cnt = r_hex_cnt;
        n_acc     = r_acc;
        w_has     = 1'b0;
        o_job     = '0;
        unique case (r_mode)
            M_IDLE: begin
                if (i_byte == C_QUOTE) begin
                    n_mode = M_STR;
                end else begin
                    w_has      = 1'b1;
                    o_job.kind = K_NOQUOTE;
                end
            end
            M_STR: begin
                if (i_byte == C_QUOTE) begin
                    w_has      = 1'b1;
                    o_job.kind = K_END;
                    n_mode     = M_IDLE;
                end else if (i_byte == C_NUL) begin
                    w_has      = 1'b1;
                    o_job.kind = K_UNTERM;
                    n_mode     = M_IDLE;
                end else if (i_byte == C_BSL) begin
                    n_mode = M_ESC;
                end else begin
                    w_has          = 1'b1;
                    o_job.kind     = K_BYTE;
                    o_job.bytes[0] = i_byte;
                end
            end
            M_ESC: begin
                w_has      = 1'b1;
                o_job.kind = K_BYTE;
                n_mode     = M_STR;
                case (i_byte)
                    C_QUOTE, C_BSL, C_SLASH: o_job.bytes[0] = i_byte;
                    8'h62:   o_job.bytes[0] = 8'h08;
                    8'h66:   o_job.bytes[0] = 8'h0c;
                    8'h6e:   o_job.bytes[0] = 8'h0a;
                    8'h72:   o_job.bytes[0] = 8'h0d;
                    8'h74:   o_job.bytes[0] = 8'h09;
                    8'h75: begin
                        w_has     = 1'b0;
                        n_mode    = M_HEX;
                        n_hex_cnt = '0;
                        n_acc     = '0;
                    end
                    default: begin
                        o_job.kind = K_BADESC;
                        n_mode     = M_IDLE;
                    end
                endcase
            end
            M_HEX: begin
                if (w_hex[4]) begin
                    w_has      = 1'b1;
                    o_job.kind = K_BADHEX;
                    n_mode     = M_IDLE;
                    n_hex_cnt  = '0;
                    n_acc      = '0;
                end else if (r_hex_cnt != 2'd3) begin
                    n_acc     = {r_acc[7:0], w_hex[3:0]};
                    n_hex_cnt = r_hex_cnt + 2'd1;
                end else begin
                    // Fourth digit: encode as UTF-8
                    w_has      = 1'b1;
                    o_job.kind = K_BYTE;
                    n_mode     = M_STR;
                    n_hex_cnt  = '0;
                    n_acc      = '0;
                    if (w_code < 16'h0080) begin
                        o_job.bytes[0] = w_code[7:0];
                    end else if (w_code < 16'h0800) begin
                        o_job.last_idx = 2'd1;
                        o_job.bytes[0] = 8'hc0 | {3'b000, w_code[10:6]};
                        o_job.bytes[1] = 8'h80 | {2'b00, w_code[5:0]};
                    end else begin
                        o_job.last_idx = 2'd2;
                        o_job.bytes[0] = 8'he0 | {4'h0, w_code[15:12]};
                        o_job.bytes[1] = 8'h80 | {2'b00, w_code[11:6]};
                        o_job.bytes[2] = 8'h80 | {2'b00, w_code[5:0]};
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_IDLE;
            r_hex_cnt <= '0;
            r_acc     <= '0;
        end else if (w_take) begin
            r_mode    <= n_mode;
            r_hex_cnt <= n_hex_cnt;
            r_acc     <= n_acc;
        end
    end

endmodule

@@ sv/jsu_queue.sv @@
// ----------------------------------------------------------------------------
// jsu_queue
// Small job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_data,
    input  logic    i_pop,
    output t_job    o_data,
    output t_q_stat o_stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ sv/jsu_back.sv @@
// ----------------------------------------------------------------------------
// jsu_back
// Output side: walks each queued job one result per cycle into the output
// register, unless the receiver stalls it.
// ----------------------------------------------------------------------------
module jsu_back
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic [2:0] o_kind,
    output logic       o_last
);

    logic [1:0] r_idx, n_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic [2:0] r_kind;
    logic       r_last;
    logic       w_load;
    logic       w_is_last;

    assign w_load    = (!r_valid || i_ready) && !i_q_stat.empty;
    assign w_is_last = (r_idx == i_job.last_idx);
    assign o_pop     = w_load && w_is_last;
    assign n_idx     = w_is_last ? 2'd0 : r_idx + 2'd1;

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_kind  = r_kind;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= n_idx;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload holds until the next load
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_job.bytes[r_idx];
            r_kind <= i_job.kind;
            r_last <= w_is_last;
        end
    end

endmodule

@@ sv/json_string_unescape.sv @@
// ----------------------------------------------------------------------------
// json_string_unescape
// Streaming unescaper for one quoted JSON string, UTF-8 output.
// ----------------------------------------------------------------------------
// Input channel: one text byte per transfer on i_in_byte (i_in_valid /
// o_in_ready). Output channel: one result per transfer with o_out_byte,
// o_kind and o_last (o_out_valid / i_out_ready); o_last marks the final
// result caused by an input byte.
// An input byte is classified in the cycle it is taken and its results sit
// in a job queue of QUEUE_DEPTH entries, from which the back end loads them
// into the output register. Bytes that only change mode (opening quote,
// backslash, the u of a \u escape, leading hex digits) give no result.
// Throughput: one input byte per cycle for plain text and simple escapes
// while the queue is not full; the 1 to 3 UTF-8 bytes of a \u escape drain
// at one result per cycle unless stalled, via the single output register.
// When the receiver stalls the output register holds, the queue fills and
// o_in_ready drops only once the queue is full.
// Reset returns to idle (awaiting an opening quote) and empties the queue.
// ----------------------------------------------------------------------------
module json_string_unescape
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_kind,
    output logic       o_last
);

`include "json_string_unescape_assert.svh"

    logic    w_push;
    logic    w_pop;
    t_job    w_job_in;
    t_job    w_job_out;
    t_q_stat w_q_stat;

    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_byte   (i_in_byte),
        .i_q_stat (w_q_stat),
        .o_ready  (o_in_ready),
        .o_push   (w_push),
        .o_job    (w_job_in)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_stat  (w_q_stat)
    );

    jsu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (w_job_out),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_byte   (o_out_byte),
        .o_kind   (o_kind),
        .o_last   (o_last)
    );

    `JSU_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, w_push, !w_q_stat.full)
    `JSU_ASSERT_NOW(a_no_pop_when_empty, i_clk, i_rst_n, w_pop, !w_q_stat.empty)
    `JSU_ASSERT_NOW(a_marker_is_single, i_clk, i_rst_n, o_out_valid && o_kind != K_BYTE, o_last)
    `JSU_ASSERT_NEXT(a_pop_ends_item, i_clk, i_rst_n, w_pop, o_out_valid && o_last)

endmodule
